// ===== src/scaled_glyph_row_renderer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scaled glyph row renderer
// Concurrent checks clocked by clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_ROW_RENDERER_ASSERT_SVH
`define SCALED_GLYPH_ROW_RENDERER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SGR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgr assertion failed");
// Next-cycle implication.
`define SGR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgr assertion failed");
`else
`define SGR_ASSERT_IMP(name, ante, cons)
`define SGR_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== src/sgr_pkg.sv =====
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types, constants and the 5x7 font ROM of the glyph row renderer.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int BLOCK_W     = 2;
  localparam int BLOCK_H     = 3;
  localparam int GLYPH_ROWS  = 7;
  localparam int ROM_ROWS    = 7;
  localparam int ROM_GLYPHS  = 36;
  localparam int MAX_RESULTS = 30;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int SY_W        = 2;
  localparam int PIX_W       = 11;
  localparam int ADDR_W      = 23;

  localparam logic [11:0] MAX_SCREEN = 12'd2048;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH    = 2'd2;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [12:0] line_pitch_words;
  } sgr_cfg_t;

  // One queued glyph row; ytop is the screen y of its first sub-row.
  typedef struct packed {
    logic signed [11:0] ox;
    logic signed [12:0] ytop;
    logic [31:0]        ink;
  } sgr_item_t;

  localparam logic [4:0] FONT_ROM [0:ROM_GLYPHS-1][0:ROM_ROWS-1] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
    '{5'h1F, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h1F},
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
    '{5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F},
    '{5'h1F, 5'h11, 5'h10, 5'h1E, 5'h10, 5'h11, 5'h1F},
    '{5'h1F, 5'h11, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
    '{5'h0E, 5'h11, 5'h10, 5'h1F, 5'h11, 5'h11, 5'h0C},
    '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h1F, 5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h11, 5'h11, 5'h12, 5'h14, 5'h16, 5'h13, 5'h11},
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h11, 5'h1F},
    '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h15, 5'h11, 5'h11},
    '{5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11},
    '{5'h0C, 5'h13, 5'h13, 5'h13, 5'h13, 5'h13, 5'h0C},
    '{5'h1F, 5'h11, 5'h11, 5'h1F, 5'h10, 5'h10, 5'h10},
    '{5'h0C, 5'h13, 5'h13, 5'h13, 5'h19, 5'h13, 5'h0A},
    '{5'h1F, 5'h11, 5'h11, 5'h1F, 5'h12, 5'h14, 5'h13},
    '{5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
    '{5'h11, 5'h11, 5'h15, 5'h15, 5'h1D, 5'h1B, 5'h11},
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
    '{5'h0C, 5'h13, 5'h15, 5'h19, 5'h11, 5'h13, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F},
    '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
    '{5'h02, 5'h03, 5'h04, 5'h08, 5'h1F, 5'h08, 5'h08},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}
  };

  // Font bits of one row, leftmost column in the highest used bit.
  // Codes other than uppercase letters and digits are blank.
  function automatic logic [7:0] font_bits(input logic [7:0] code, input logic [2:0] row);
    logic [5:0] idx;
    logic       hit;
    idx = '0;
    hit = 1'b0;
    if (code inside {[8'h41:8'h5A]}) begin
      idx = 6'(code - 8'h41);
      hit = 1'b1;
    end else if (code inside {[8'h30:8'h39]}) begin
      idx = 6'(code - 8'h30) + 6'd26;
      hit = 1'b1;
    end
    if (!hit || int'(row) >= ROM_ROWS || int'(row) >= GLYPH_ROWS) begin
      return 8'h00;
    end
    return {3'b000, FONT_ROM[idx][row]};
  endfunction

endpackage

// ===== src/sgr_ram.sv =====
// ----------------------------------------------------------------------------
// sgr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sgr_front.sv =====
// ----------------------------------------------------------------------------
// sgr_front
// Registers a request and builds the visibility mask of its pixels.
// ----------------------------------------------------------------------------
module sgr_front #(
  parameter int GLYPH_COLS = 5,
  localparam int MASK_W = GLYPH_COLS * sgr_pkg::BLOCK_W * sgr_pkg::BLOCK_H
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         char_code,
  input  logic [2:0]         glyph_row,
  input  logic signed [11:0] origin_x,
  input  logic signed [11:0] origin_y,
  input  logic [31:0]        ink_colour,
  input  sgr_pkg::sgr_cfg_t  cfg,
  output logic               wr_en,
  output logic               drop,
  output logic [MASK_W-1:0]  mask,
  output sgr_pkg::sgr_item_t item
);
  import sgr_pkg::*;

  logic               s0v_r;
  logic [7:0]         code_r;
  logic [2:0]         row_r;
  logic signed [11:0] ox_r;
  logic signed [11:0] oy_r;
  logic [31:0]        ink_r;

  logic [11:0] wlim;
  logic [11:0] hlim;
  logic [7:0]  rowbits;
  logic [4:0]  row3;
  logic [13:0] ytop;
  logic [13:0] ys [BLOCK_H];
  logic [13:0] xs [GLYPH_COLS*BLOCK_W];
  logic [BLOCK_H-1:0]            yv;
  logic [GLYPH_COLS*BLOCK_W-1:0] xv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0v_r <= 1'b0;
    end else begin
      s0v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code_r <= char_code;
      row_r  <= glyph_row;
      ox_r   <= origin_x;
      oy_r   <= origin_y;
      ink_r  <= ink_colour;
    end
  end

  always_comb begin
    wlim    = (cfg.screen_width  > MAX_SCREEN) ? MAX_SCREEN : cfg.screen_width;
    hlim    = (cfg.screen_height > MAX_SCREEN) ? MAX_SCREEN : cfg.screen_height;
    rowbits = font_bits(code_r, row_r);
    row3    = {2'b00, row_r} + {1'b0, row_r, 1'b0};
    ytop    = {{2{oy_r[11]}}, oy_r} + {9'd0, row3};
    for (int sy = 0; sy < BLOCK_H; sy++) begin
      ys[sy] = ytop + 14'(sy);
      yv[sy] = !ys[sy][13] && (ys[sy] < {2'b00, hlim});
    end
    for (int k = 0; k < GLYPH_COLS * BLOCK_W; k++) begin
      xs[k] = {{2{ox_r[11]}}, ox_r} + 14'(k);
      xv[k] = !xs[k][13] && (xs[k] < {2'b00, wlim});
    end
    mask = '0;
    for (int j = 0; j < GLYPH_COLS; j++) begin
      for (int sy = 0; sy < BLOCK_H; sy++) begin
        for (int sx = 0; sx < BLOCK_W; sx++) begin
          mask[(j*BLOCK_H + sy)*BLOCK_W + sx] =
            rowbits[GLYPH_COLS-1-j] & yv[sy] & xv[j*BLOCK_W + sx];
        end
      end
    end
  end

  // A visible pixel bounds ytop to a few lines above zero, so 13 bits hold it.
  assign item.ox   = ox_r;
  assign item.ytop = ytop[12:0];
  assign item.ink  = ink_r;

  assign wr_en = s0v_r && (mask != '0);
  assign drop  = s0v_r && (mask == '0);

endmodule

// ===== src/sgr_emit.sv =====
// ----------------------------------------------------------------------------
// sgr_emit
// Takes queued glyph rows and streams their visible pixels, one per cycle.
// ----------------------------------------------------------------------------
`include "scaled_glyph_row_renderer_assert.svh"

module sgr_emit #(
  parameter int GLYPH_COLS = 5,
  localparam int MASK_W = GLYPH_COLS * sgr_pkg::BLOCK_W * sgr_pkg::BLOCK_H
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [12:0]        line_pitch,
  input  logic               q_valid,
  input  logic [MASK_W-1:0]  q_mask,
  input  sgr_pkg::sgr_item_t q_item,
  output logic               q_take,
  output logic               out_strobe,
  output logic [10:0]        out_pixel_x,
  output logic [10:0]        out_pixel_y,
  output logic [22:0]        out_pixel_address,
  output logic [31:0]        out_pixel_colour,
  output logic               out_last_pixel
);
  import sgr_pkg::*;

  localparam int JW = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;

  // Product stage.
  logic               pv_r;
  logic [MASK_W-1:0]  p_mask_r;
  sgr_item_t          p_item_r;
  logic [ADDR_W-1:0]  p_base_r;
  logic signed [26:0] prod;
  logic               p_take;

  // Pick stage.
  logic              ev_r;
  logic              ev_nxt;
  logic [MASK_W-1:0] e_mask_r;
  sgr_item_t         e_item_r;
  logic [ADDR_W-1:0] e_base_r;
  logic [CNT_W-1:0]  e_cnt_r;
  logic [MASK_W-1:0] pick_hot;
  logic [MASK_W-1:0] mask_rest;
  logic [JW-1:0]     pick_j;
  logic [SY_W-1:0]   pick_sy;
  logic              pick_sx;
  logic              e_last;
  logic              e_free;

  // Pixel stage.
  logic              fv_r;
  logic [JW-1:0]     f_j_r;
  logic [SY_W-1:0]   f_sy_r;
  logic              f_sx_r;
  logic              f_last_r;
  sgr_item_t         f_item_r;
  logic [ADDR_W-1:0] f_base_r;
  logic [13:0]       px;
  logic [13:0]       py;
  logic [ADDR_W-1:0] row_off;
  logic [ADDR_W-1:0] addr;

  logic              out_strobe_r;
  logic [10:0]       out_x_r;
  logic [10:0]       out_y_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [31:0]       out_colour_r;
  logic              out_last_r;

  // Signed row start times pitch; only the low address bits matter.
  assign prod = $signed(q_item.ytop) * $signed({1'b0, line_pitch});

  // Lowest set mask bit is the next pixel in column, sub-row, sub-column order.
  always_comb begin
    pick_hot = '0;
    pick_j   = '0;
    pick_sy  = '0;
    pick_sx  = 1'b0;
    for (int j = GLYPH_COLS - 1; j >= 0; j--) begin
      for (int sy = BLOCK_H - 1; sy >= 0; sy--) begin
        for (int sx = BLOCK_W - 1; sx >= 0; sx--) begin
          if (e_mask_r[(j*BLOCK_H + sy)*BLOCK_W + sx]) begin
            pick_hot = '0;
            pick_hot[(j*BLOCK_H + sy)*BLOCK_W + sx] = 1'b1;
            pick_j  = JW'(j);
            pick_sy = SY_W'(sy);
            pick_sx = 1'(sx);
          end
        end
      end
    end
  end

  assign mask_rest = e_mask_r & ~pick_hot;
  assign e_last    = ev_r && ((mask_rest == '0) || (e_cnt_r == CNT_W'(MAX_RESULTS - 1)));
  assign e_free    = !ev_r || e_last;
  assign p_take    = pv_r && e_free;
  assign q_take    = q_valid && (!pv_r || p_take);
  assign ev_nxt    = e_free ? pv_r : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r         <= 1'b0;
      ev_r         <= 1'b0;
      fv_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      pv_r         <= q_take || (pv_r && !p_take);
      ev_r         <= ev_nxt;
      fv_r         <= ev_r;
      out_strobe_r <= fv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      p_mask_r <= q_mask;
      p_item_r <= q_item;
      p_base_r <= prod[ADDR_W-1:0];
    end
    if (p_take) begin
      e_mask_r <= p_mask_r;
      e_item_r <= p_item_r;
      e_base_r <= p_base_r;
      e_cnt_r  <= '0;
    end else if (ev_r && !e_last) begin
      e_mask_r <= mask_rest;
      e_cnt_r  <= e_cnt_r + 1'b1;
    end
    if (ev_r) begin
      f_j_r    <= pick_j;
      f_sy_r   <= pick_sy;
      f_sx_r   <= pick_sx;
      f_last_r <= e_last;
      f_item_r <= e_item_r;
      f_base_r <= e_base_r;
    end
  end

  always_comb begin
    px = {{2{f_item_r.ox[11]}}, f_item_r.ox} + 14'(int'(f_j_r) * BLOCK_W + int'(f_sx_r));
    py = {f_item_r.ytop[12], f_item_r.ytop} + 14'(f_sy_r);
    case (f_sy_r)
      2'd0:    row_off = '0;
      2'd1:    row_off = {10'd0, line_pitch};
      2'd2:    row_off = {9'd0, line_pitch, 1'b0};
      default: row_off = '0;
    endcase
    addr = f_base_r + row_off + {12'd0, px[PIX_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (fv_r) begin
      out_x_r      <= px[PIX_W-1:0];
      out_y_r      <= py[PIX_W-1:0];
      out_addr_r   <= addr;
      out_colour_r <= f_item_r.ink;
      out_last_r   <= f_last_r;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_pixel_x       = out_x_r;
  assign out_pixel_y       = out_y_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_colour  = out_colour_r;
  assign out_last_pixel    = out_last_r;

  `SGR_ASSERT_IMP(a_pick_nonempty, ev_r, e_mask_r != '0)
  `SGR_ASSERT_IMP(a_cnt_capped, ev_r, e_cnt_r < CNT_W'(MAX_RESULTS))
  `SGR_ASSERT_NEXT(a_take_fills, q_take, pv_r)

endmodule

// ===== src/scaled_glyph_row_renderer.sv =====
// ----------------------------------------------------------------------------
// scaled_glyph_row_renderer
// Draws one row of a 5x7 font glyph, scaled 2x3, as a stream of pixel writes.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Beat
// request   in         start high, busy low  one glyph row request
// pixel     out        out_strobe, 1 cycle   one visible pixel write
// config    in         cfg_we                one register write
//
// The block emits one pixel per cycle. A request with n visible pixels (at
// most 30) yields n pixel writes, a fully clipped one none. A first pixel
// passes the front, RAM read, product, pick, pixel and output registers.
// Up to QUEUE_DEPTH requests wait in the front stage and queue memory; busy
// is high while they are full. Reset is synchronous and clears all control
// state. The receiver cannot stall: every strobed pixel is taken in its cycle.
//
// Accepted requests pass a register stage that looks up the font row and
// forms a visibility mask with one bit per pixel of the scaled row. Rows with
// no visible pixel are dropped there. Others are written, mask and all, into
// the queue RAM. The reader fetches entries with a registered read,
// multiplies the row start by the line pitch, and the emitter then walks the
// mask lowest bit first, which gives column, sub-row, sub-column order.
// An entry is read only after the edge that wrote it, so the write and read
// ports never touch the same entry in one cycle.
// ----------------------------------------------------------------------------
`include "scaled_glyph_row_renderer_assert.svh"

module scaled_glyph_row_renderer #(
  parameter int GLYPH_COLS  = 5,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_char_code,
  input  logic [2:0]  in_glyph_row,
  input  logic signed [11:0] in_origin_x,
  input  logic signed [11:0] in_origin_y,
  input  logic [31:0] in_ink_colour,
  input  logic        cfg_we,
  input  logic [sgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [12:0] cfg_wdata,
  output logic        out_strobe,
  output logic [10:0] out_pixel_x,
  output logic [10:0] out_pixel_y,
  output logic [22:0] out_pixel_address,
  output logic [31:0] out_pixel_colour,
  output logic        out_last_pixel
);
  import sgr_pkg::*;

  localparam int MASK_W  = GLYPH_COLS * BLOCK_W * BLOCK_H;
  localparam int ITEM_W  = $bits(sgr_item_t);
  localparam int ENTRY_W = MASK_W + ITEM_W;
  localparam int AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OW      = $clog2(QUEUE_DEPTH + 1);

  sgr_cfg_t cfg_r;

  logic          accept;
  logic          wr_en;
  logic          drop;
  logic          rd_en;
  logic          q_take;
  logic          qv_r;
  logic [MASK_W-1:0] f_mask;
  sgr_item_t     f_item;
  logic [ENTRY_W-1:0] rdata;

  // occ_r counts requests held in the front stage and in the RAM;
  // ram_cnt_r counts RAM entries written and not yet read.
  logic [OW-1:0] occ_r;
  logic [OW-1:0] occ_nxt;
  logic [OW-1:0] ram_cnt_r;
  logic [OW-1:0] ram_cnt_nxt;
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width     <= 12'd640;
      cfg_r.screen_height    <= 12'd480;
      cfg_r.line_pitch_words <= 13'd640;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  cfg_r.screen_width     <= cfg_wdata[11:0];
        CFG_SCREEN_HEIGHT: cfg_r.screen_height    <= cfg_wdata[11:0];
        CFG_LINE_PITCH:    cfg_r.line_pitch_words <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy   = (occ_r == OW'(QUEUE_DEPTH));
  assign accept = start && !busy;

  sgr_front #(
    .GLYPH_COLS (GLYPH_COLS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .char_code  (in_char_code),
    .glyph_row  (in_glyph_row),
    .origin_x   (in_origin_x),
    .origin_y   (in_origin_y),
    .ink_colour (in_ink_colour),
    .cfg        (cfg_r),
    .wr_en      (wr_en),
    .drop       (drop),
    .mask       (f_mask),
    .item       (f_item)
  );

  sgr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_ptr_r),
    .wdata ({f_mask, f_item}),
    .re    (rd_en),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

  // Fetch the next entry when the read data register is free or being taken.
  assign rd_en = (ram_cnt_r != '0) && (!qv_r || q_take);

  always_comb begin
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    occ_nxt     = occ_r + OW'(accept) - OW'(drop) - OW'(rd_en);
    ram_cnt_nxt = ram_cnt_r + OW'(wr_en) - OW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      ram_cnt_r <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      qv_r      <= 1'b0;
    end else begin
      occ_r     <= occ_nxt;
      ram_cnt_r <= ram_cnt_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      qv_r      <= rd_en || (qv_r && !q_take);
    end
  end

  sgr_emit #(
    .GLYPH_COLS (GLYPH_COLS)
  ) u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .line_pitch        (cfg_r.line_pitch_words),
    .q_valid           (qv_r),
    .q_mask            (rdata[ENTRY_W-1 -: MASK_W]),
    .q_item            (sgr_item_t'(rdata[ITEM_W-1:0])),
    .q_take            (q_take),
    .out_strobe        (out_strobe),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_colour  (out_pixel_colour),
    .out_last_pixel    (out_last_pixel)
  );

  `SGR_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= OW'(QUEUE_DEPTH))
  `SGR_ASSERT_IMP(a_ram_within_occ, 1'b1, ram_cnt_r <= occ_r)
  `SGR_ASSERT_IMP(a_read_has_entry, rd_en, ram_cnt_r != '0)

endmodule
